FILE: rtl/key_frame_search_macros.svh
// Assertion macros shared by the key-frame search RTL.
`ifndef KEY_FRAME_SEARCH_MACROS_SVH
`define KEY_FRAME_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define KFS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key_frame_search: same-cycle check failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define KFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key_frame_search: next-cycle check failed");
`else
`define KFS_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define KFS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/kfs_pkg.sv
// Shared constants, codes, controller/datapath structs and bit search functions.
package kfs_pkg;

   localparam int MAX_FRAMES = 4096;
   localparam int FRAME_W    = 13;
   localparam int MODE_W     = 2;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int WORD_W     = 64;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int WORDS      = MAX_FRAMES / WORD_W;
   localparam int ADDR_W     = IDX_W - BIT_W;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [MODE_W-1:0] MODE_PREVIOUS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEXT     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd2;

   // word pointer operations
   localparam logic [1:0] WP_HOLD = 2'd0;
   localparam logic [1:0] WP_DEC  = 2'd1;
   localparam logic [1:0] WP_INC  = 2'd2;
   localparam logic [1:0] WP_Q    = 2'd3;

   // result selection
   localparam logic [1:0] RES_ZERO = 2'd0;
   localparam logic [1:0] RES_SELF = 2'd1;
   localparam logic [1:0] RES_SCAN = 2'd2;

   typedef struct packed {
      logic       capture;
      logic [1:0] wp_op;
      logic       ram_we;
      logic       dn_capture;
      logic       up_capture;
      logic       push;
      logic [1:0] res_sel;
   } kfs_cmd_type;

   typedef struct packed {
      logic              is_query;
      logic              load_ok;
      logic              query_ok;
      logic              self_hit;
      logic              skip;
      logic [MODE_W-1:0] mode;
      logic              dn_hit;
      logic              dn_end;
      logic              up_hit;
      logic              up_end;
      logic              out_busy;
   } kfs_sts_type;

   // Index of the highest set bit, by halving the window.
   function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] v;
      logic [BIT_W-1:0]  pos;
      v   = w;
      pos = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         if ((v >> (1 << k)) != '0) begin
            pos[k] = 1'b1;
            v      = v >> (1 << k);
         end
      end
      return pos;
   endfunction

   // Index of the lowest set bit, by halving the window.
   function automatic logic [BIT_W-1:0] bottom_bit(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] v;
      logic [BIT_W-1:0]  pos;
      v   = w;
      pos = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         if ((v & ({WORD_W{1'b1}} >> (WORD_W - (1 << k)))) == '0) begin
            pos[k] = 1'b1;
            v      = v >> (1 << k);
         end
      end
      return pos;
   endfunction

endpackage

FILE: rtl/kfs_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface kfs_req_if;
   import kfs_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [FRAME_W-1:0] frame_number;
   logic              key_flag;
   logic [MODE_W-1:0] search_mode;
   logic              skip_equal;

   modport source (output valid, kind, frame_number, key_flag, search_mode, skip_equal,
                   input ready);
   modport sink   (input valid, kind, frame_number, key_flag, search_mode, skip_equal,
                   output ready);
endinterface

interface kfs_rsp_if;
   import kfs_pkg::*;
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] found_frame;

   modport source (output valid, found_frame, input ready);
   modport sink   (input valid, found_frame, output ready);
endinterface

FILE: rtl/key_frame_search.sv
// Top level of the key-frame search block: controller, datapath and flag memory.
//
// Usage:
//   req_if  : valid/ready request channel. kind = load writes key_flag for the
//             one-based frame_number; kind = query searches from frame_number
//             in search_mode (previous, next, nearest), honoring skip_equal.
//   rsp_if  : valid/ready response channel, one transfer per query carrying
//             found_frame (0 when nothing is found). Loads produce no transfer.
//   csr_wr_en / csr_wr_data : write frame_count while the block is idle.
// Controller states after the request transfer, up to the response register:
//   load                 : DISPATCH, LOAD (valid frames only), then IDLE
//   invalid frame        : DISPATCH, then DONE
//   queried frame is key : DISPATCH, EQ, DONE
//   previous / next      : DISPATCH, EQ, DOWN or UP over 1 to 64 words, DONE
//   nearest              : DISPATCH, EQ, DOWN words, UP_FILL, UP words, DONE
// The scan reads one 64-flag word per cycle from the flag memory read port;
// that memory port sets the throughput. One item is handled at a time.
// Reset clears the control state and frame_count; the flag memory is not
// cleared, so only loaded flags are meaningful. A stalled receiver holds the
// response register; a new request is still taken, and its result waits.
module key_frame_search (
   input  logic                        clock,
   input  logic                        reset,
   kfs_req_if.sink                     req_if,
   kfs_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [kfs_pkg::FRAME_W-1:0] csr_wr_data
);
   import kfs_pkg::*;

   kfs_cmd_type       cmd;
   kfs_sts_type       sts;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;
   logic              req_ready;

   assign req_if.ready = req_ready;

   // Sequencer: decides each step from the datapath status.
   kfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: captures the request, walks the flag words, holds the response.
   kfs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_if.kind),
      .req_frame_number (req_if.frame_number),
      .req_key_flag     (req_if.key_flag),
      .req_search_mode  (req_if.search_mode),
      .req_skip_equal   (req_if.skip_equal),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_found_frame  (rsp_if.found_frame),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .cmd              (cmd),
      .sts              (sts)
   );

   // Key flags, one word of 64 frames per address; loads read-modify-write.
   kfs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );
endmodule

FILE: rtl/kfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/kfs_ctrl.sv
// Sequencer for loads, equality check and the downward/upward flag scans.
`include "key_frame_search_macros.svh"
module kfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kfs_pkg::kfs_sts_type sts,
   output kfs_pkg::kfs_cmd_type cmd
);
   import kfs_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_LOAD     = 3'd2;
   localparam logic [2:0] ST_EQ       = 3'd3;
   localparam logic [2:0] ST_DOWN     = 3'd4;
   localparam logic [2:0] ST_UP_FILL  = 3'd5;
   localparam logic [2:0] ST_UP       = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!sts.is_query) begin
               state_in = sts.load_ok ? ST_LOAD : ST_IDLE;
            end else if (!sts.query_ok) begin
               sel_in   = RES_ZERO;
               state_in = ST_DONE;
            end else begin
               state_in = ST_EQ;
            end
         end
         ST_LOAD: begin
            cmd.ram_we = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_EQ: begin
            if (!sts.skip && sts.self_hit) begin
               sel_in   = RES_SELF;
               state_in = ST_DONE;
            end else begin
               case (sts.mode)
                  MODE_PREVIOUS, MODE_NEAREST: begin
                     cmd.wp_op = WP_DEC;
                     state_in  = ST_DOWN;
                  end
                  MODE_NEXT: begin
                     cmd.wp_op = WP_INC;
                     state_in  = ST_UP;
                  end
                  default: begin
                     sel_in   = RES_ZERO;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DOWN: begin
            cmd.dn_capture = sts.dn_hit;
            if (sts.dn_hit || sts.dn_end) begin
               if (sts.mode == MODE_NEAREST) begin
                  // rewind to the query word for the upward half
                  cmd.wp_op = WP_Q;
                  state_in  = ST_UP_FILL;
               end else begin
                  sel_in   = RES_SCAN;
                  state_in = ST_DONE;
               end
            end else begin
               cmd.wp_op = WP_DEC;
            end
         end
         ST_UP_FILL: begin
            cmd.wp_op = WP_INC;
            state_in  = ST_UP;
         end
         ST_UP: begin
            cmd.up_capture = sts.up_hit;
            if (sts.up_hit || sts.up_end) begin
               sel_in   = RES_SCAN;
               state_in = ST_DONE;
            end else begin
               cmd.wp_op = WP_INC;
            end
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.push    = 1'b1;
               cmd.res_sel = sel_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= RES_ZERO;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   `KFS_ASSERT_NEXT(a_capture_dispatch, clock, reset, cmd.capture, state_ff == ST_DISPATCH)
   `KFS_ASSERT_NEXT(a_done_exit, clock, reset, state_ff == ST_DONE, (state_ff == ST_DONE) || (state_ff == ST_IDLE))
   `KFS_ASSERT_NEXT(a_load_then_idle, clock, reset, cmd.ram_we, req_ready && !cmd.push)
endmodule

FILE: rtl/kfs_datapath.sv
// Field registers, word pointer, masked priority search and response register.
`include "key_frame_search_macros.svh"
module kfs_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_kind,
   input  logic [kfs_pkg::FRAME_W-1:0]  req_frame_number,
   input  logic                         req_key_flag,
   input  logic [kfs_pkg::MODE_W-1:0]   req_search_mode,
   input  logic                         req_skip_equal,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [kfs_pkg::FRAME_W-1:0]  rsp_found_frame,
   input  logic                         csr_wr_en,
   input  logic [kfs_pkg::FRAME_W-1:0]  csr_wr_data,
   output logic                         ram_wr_en,
   output logic [kfs_pkg::ADDR_W-1:0]   ram_wr_addr,
   output logic [kfs_pkg::WORD_W-1:0]   ram_wr_data,
   output logic [kfs_pkg::ADDR_W-1:0]   ram_rd_addr,
   input  logic [kfs_pkg::WORD_W-1:0]   ram_rd_data,
   input  kfs_pkg::kfs_cmd_type         cmd,
   output kfs_pkg::kfs_sts_type         sts
);
   import kfs_pkg::*;

   localparam logic [WORD_W-1:0]  ONES      = '1;
   localparam logic [WORD_W-1:0]  BIT0      = WORD_W'(1);
   localparam logic [FRAME_W-1:0] MAX_COUNT = FRAME_W'(MAX_FRAMES);
   localparam logic [FRAME_W-1:0] ONE_F     = FRAME_W'(1);

   logic               kind_ff, kind_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               flag_ff, flag_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               skip_ff, skip_in;
   logic [IDX_W-1:0]   q_ff, q_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [ADDR_W-1:0]  rp_ff, rp_in;
   logic [IDX_W-1:0]   p_ff, p_in;
   logic               p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic               n_valid_ff, n_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_found_ff, rsp_found_in;
   logic [FRAME_W-1:0] frame_count_ff, frame_count_in;

   logic [FRAME_W-1:0] count_eff;
   logic [FRAME_W-1:0] last_full;
   logic [IDX_W-1:0]   last_idx;
   logic [FRAME_W-1:0] req_q_full;
   logic [ADDR_W-1:0]  q_word;
   logic [BIT_W-1:0]   q_bit;
   logic [ADDR_W-1:0]  last_word;
   logic [BIT_W-1:0]   last_bit;
   logic [WORD_W-1:0]  dn_seed;
   logic [WORD_W-1:0]  dn_masked;
   logic [WORD_W-1:0]  up_lo_mask;
   logic [WORD_W-1:0]  up_hi_mask;
   logic [WORD_W-1:0]  up_masked;
   logic [BIT_W-1:0]   dn_pos;
   logic [BIT_W-1:0]   up_pos;
   logic               load_ok;
   logic [IDX_W-1:0]   dist_dn;
   logic [IDX_W-1:0]   dist_up;
   logic               take_dn;
   logic [IDX_W-1:0]   scan_idx;
   logic [FRAME_W-1:0] scan_frame;
   logic [FRAME_W-1:0] result;

   // frame_count above the table size acts as the table size
   assign count_eff  = (frame_count_ff > MAX_COUNT) ? MAX_COUNT : frame_count_ff;
   assign last_full  = count_eff - ONE_F;
   assign last_idx   = last_full[IDX_W-1:0];
   assign last_word  = last_idx[IDX_W-1:BIT_W];
   assign last_bit   = last_idx[BIT_W-1:0];
   assign req_q_full = req_frame_number - ONE_F;
   assign q_word     = q_ff[IDX_W-1:BIT_W];
   assign q_bit      = q_ff[BIT_W-1:0];

   assign load_ok = (frame_ff != '0) && (frame_ff <= MAX_COUNT);

   // Downward search: bits below the query in its own word; previous mode
   // treats frame 1 as a key frame so it is the fallback.
   assign dn_seed   = ((rp_ff == '0) && (mode_ff == MODE_PREVIOUS)) ? BIT0 : '0;
   assign dn_masked = (ram_rd_data | dn_seed) & ((rp_ff == q_word) ? ~(ONES << q_bit) : ONES);
   assign dn_pos    = top_bit(dn_masked);

   // Upward search: bits above the query, up to the last counted frame.
   assign up_lo_mask = (rp_ff == q_word) ? ((ONES << q_bit) << 1) : ONES;
   assign up_hi_mask = (rp_ff == last_word) ? (ONES >> (~last_bit)) : ONES;
   assign up_masked  = ram_rd_data & up_lo_mask & up_hi_mask;
   assign up_pos     = bottom_bit(up_masked);

   // Nearest pick, ties go downward.
   assign dist_dn    = q_ff - p_ff;
   assign dist_up    = n_ff - q_ff;
   assign take_dn    = p_valid_ff && (!n_valid_ff || (dist_dn <= dist_up));
   assign scan_idx   = take_dn ? p_ff : n_ff;
   assign scan_frame = (p_valid_ff || n_valid_ff) ? (FRAME_W'(scan_idx) + ONE_F) : '0;

   always_comb begin
      case (cmd.res_sel)
         RES_SELF: result = frame_ff;
         RES_SCAN: result = scan_frame;
         default:  result = '0;
      endcase
   end

   always_comb begin
      ram_wr_data        = ram_rd_data;
      ram_wr_data[q_bit] = flag_ff;
   end
   assign ram_wr_en   = cmd.ram_we;
   assign ram_wr_addr = q_word;
   assign ram_rd_addr = wp_ff;

   always_comb begin
      kind_in        = kind_ff;
      frame_in       = frame_ff;
      flag_in        = flag_ff;
      mode_in        = mode_ff;
      skip_in        = skip_ff;
      q_in           = q_ff;
      p_in           = p_ff;
      p_valid_in     = p_valid_ff;
      n_in           = n_ff;
      n_valid_in     = n_valid_ff;
      rp_in          = wp_ff;
      frame_count_in = csr_wr_en ? csr_wr_data : frame_count_ff;

      case (cmd.wp_op)
         WP_DEC:  wp_in = wp_ff - 1'b1;
         WP_INC:  wp_in = wp_ff + 1'b1;
         WP_Q:    wp_in = q_word;
         default: wp_in = wp_ff;
      endcase

      if (cmd.capture) begin
         kind_in    = req_kind;
         frame_in   = req_frame_number;
         flag_in    = req_key_flag;
         mode_in    = req_search_mode;
         skip_in    = req_skip_equal;
         q_in       = req_q_full[IDX_W-1:0];
         wp_in      = req_q_full[IDX_W-1:BIT_W];
         p_valid_in = 1'b0;
         n_valid_in = 1'b0;
      end
      if (cmd.dn_capture) begin
         p_in       = {rp_ff, dn_pos};
         p_valid_in = 1'b1;
      end
      if (cmd.up_capture) begin
         n_in       = {rp_ff, up_pos};
         n_valid_in = 1'b1;
      end

      rsp_found_in = rsp_found_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      frame_ff     <= frame_in;
      flag_ff      <= flag_in;
      mode_ff      <= mode_in;
      skip_ff      <= skip_in;
      q_ff         <= q_in;
      wp_ff        <= wp_in;
      rp_ff        <= rp_in;
      p_ff         <= p_in;
      n_ff         <= n_in;
      rsp_found_ff <= rsp_found_in;
      if (reset) begin
         p_valid_ff     <= 1'b0;
         n_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         frame_count_ff <= '0;
      end else begin
         p_valid_ff     <= p_valid_in;
         n_valid_ff     <= n_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_count_ff <= frame_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_frame = rsp_found_ff;

   always_comb begin
      sts          = '0;
      sts.is_query = (kind_ff == KIND_QUERY);
      sts.load_ok  = load_ok;
      sts.query_ok = (frame_ff != '0) && (frame_ff <= count_eff);
      sts.self_hit = ram_rd_data[q_bit];
      sts.skip     = skip_ff;
      sts.mode     = mode_ff;
      sts.dn_hit   = (dn_masked != '0);
      sts.dn_end   = (rp_ff == '0);
      sts.up_hit   = (up_masked != '0);
      sts.up_end   = (rp_ff == last_word);
      sts.out_busy = rsp_valid_ff && !rsp_ready;
   end

   `KFS_ASSERT_IMPLY(a_push_free_slot, clock, reset, cmd.push, !(rsp_valid_ff && !rsp_ready))
   `KFS_ASSERT_IMPLY(a_write_on_load, clock, reset, cmd.ram_we, (kind_ff == KIND_LOAD) && load_ok)
   `KFS_ASSERT_NEXT(a_up_in_range, clock, reset, cmd.up_capture, n_valid_ff && (n_ff > q_ff) && (n_ff <= last_idx))
endmodule
